[rtl/ffba_pkg.sv]
// Shared constants and types for the first-fit block allocator.
package ffba_pkg;
	localparam int MaxBlocks   = 64;
	localparam int SlotW       = $clog2(MaxBlocks);
	localparam int LinkW       = SlotW + 1;
	localparam int HeaderBytes = 16;

	localparam logic [LinkW-1:0] NoLink = LinkW'(MaxBlocks);
	localparam logic [31:0] Hdr32 = 32'(HeaderBytes);

	localparam logic [2:0] StOk       = 3'd0;
	localparam logic [2:0] StZeroSize = 3'd1;
	localparam logic [2:0] StNoMemory = 3'd2;
	localparam logic [2:0] StNotFound = 3'd3;
	localparam logic [2:0] StNullAddr = 3'd4;

	localparam logic CfgBase = 1'b0;
	localparam logic CfgSize = 1'b1;

	typedef struct packed {
		logic [31:0]      start;
		logic [31:0]      size;
		logic             free;
		logic [LinkW-1:0] nxt;
		logic [LinkW-1:0] prv;
	} entry_t;

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_WALK_RD, S_WALK_CHK, S_ALLOC_WR, S_NEW_WR, S_FIX_AFTER,
		S_NX_RD, S_NX_CHK, S_MERGE_NX, S_PV_RD, S_PV_CHK, S_FIX_AFTER2,
		S_DONE
	} state_t;
endpackage

[rtl/ffba_table.sv]
// Block table memory: one write port, one registered read port.
module ffba_table (
	input  logic                          clk,
	input  logic                          we,
	input  logic [ffba_pkg::SlotW-1:0]    waddr,
	input  ffba_pkg::entry_t              wdata,
	input  logic [ffba_pkg::SlotW-1:0]    raddr,
	output ffba_pkg::entry_t              rdata
);
	ffba_pkg::entry_t mem [ffba_pkg::MaxBlocks];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

[rtl/first_fit_block_allocator_core.sv]
// Top level: first-fit allocator with merging on free over a block table memory.
//  channel | dir | payload
//  s_axis  | in  | tdata: kind[0], request_size[32:1], buffer_address[64:33]
//  m_axis  | out | tdata: status[2:0], user_address[34:3], granted_size[66:35]
//  cfg     | in  | cfg_we, cfg_index (0 base, 1 size), cfg_data
// One item at a time: each block walked takes a read state and a check state
// (memory read latency in the list walk), then split or merge writes and the
// result follow; the next item is accepted only once back in idle.
// After reset or a size register write while idle, a clearing pass writes every
// table slot before items are taken; another size write during it restarts it.
// The result is held in an output register; while it waits, s_axis_tready is low.
module first_fit_block_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [71:0] s_axis_tdata,  // kind, request_size, buffer_address
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [71:0] m_axis_tdata,  // status, user_address, granted_size
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int SW = ffba_pkg::SlotW;
	localparam int LW = ffba_pkg::LinkW;

	ffba_pkg::state_t st_q, st_d;
	logic [31:0] base_q, size_q;
	logic [ffba_pkg::MaxBlocks-1:0] spare_q;
	logic [LW-1:0] cnt_q;
	logic kind_q;
	logic [31:0] req_q, want_q;
	logic [LW-1:0] cur_q, nx_q;
	ffba_pkg::entry_t ce_q, re;
	logic [SW-1:0] spare_idx;
	logic spare_ok;
	logic mrg_q;
	logic [2:0] ost_q;
	logic [31:0] ou_q, og_q;
	logic ov_q;
	logic size_wr;

	logic we;
	logic [SW-1:0] waddr, raddr;
	ffba_pkg::entry_t wdata;
	logic [LW-1:0] after_q;

	ffba_table u_tab (.clk, .we, .waddr, .wdata, .raddr, .rdata(re));

	assign size_wr = cfg_we && (cfg_index == ffba_pkg::CfgSize);

	// first spare slot
	always_comb begin
		logic found;
		found = 1'b0;
		spare_idx = '0;
		for (int i = 0; i < ffba_pkg::MaxBlocks; i++)
			if (spare_q[i] && !found) begin
				found = 1'b1;
				spare_idx = SW'(i);
			end
		spare_ok = found;
	end

	logic hit, is_last, walk_end;
	always_comb begin
		hit = kind_q ? (re.start == want_q) : (re.free && re.size >= req_q);
		is_last = (cnt_q == LW'(ffba_pkg::MaxBlocks - 1));
	end
	assign walk_end = (re.nxt[LW-1] == 1'b1) || is_last;

	assign s_axis_tready = (st_q == ffba_pkg::S_IDLE) && !ov_q;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {5'b0, og_q, ou_q, ost_q};

	logic split;
	assign split = ({1'b0, ce_q.size} > {1'b0, req_q} + 33'(2 * ffba_pkg::HeaderBytes))
		&& spare_ok;

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ffba_pkg::S_INIT: if (is_last && !size_wr) st_d = ffba_pkg::S_IDLE;
			ffba_pkg::S_IDLE: begin
				if (size_wr) st_d = ffba_pkg::S_INIT;
				else if (s_axis_tvalid && s_axis_tready) begin
					if (s_axis_tdata[0] ? (s_axis_tdata[64:33] == 32'd0)
						: (s_axis_tdata[32:1] == 32'd0)) st_d = ffba_pkg::S_DONE;
					else st_d = ffba_pkg::S_WALK_RD;
				end
			end
			ffba_pkg::S_WALK_RD: st_d = ffba_pkg::S_WALK_CHK;
			ffba_pkg::S_WALK_CHK: begin
				if (hit) st_d = kind_q ? ffba_pkg::S_NX_RD : ffba_pkg::S_ALLOC_WR;
				else if (walk_end) st_d = ffba_pkg::S_DONE;
				else st_d = ffba_pkg::S_WALK_RD;
			end
			ffba_pkg::S_ALLOC_WR: st_d = split ? ffba_pkg::S_NEW_WR : ffba_pkg::S_DONE;
			ffba_pkg::S_NEW_WR: st_d = after_q[LW-1] ? ffba_pkg::S_DONE
				: ffba_pkg::S_FIX_AFTER;
			ffba_pkg::S_FIX_AFTER: st_d = ffba_pkg::S_DONE;
			ffba_pkg::S_NX_RD: st_d = ce_q.nxt[LW-1] ? ffba_pkg::S_PV_RD : ffba_pkg::S_NX_CHK;
			ffba_pkg::S_NX_CHK: st_d = re.free ? ffba_pkg::S_MERGE_NX : ffba_pkg::S_PV_RD;
			ffba_pkg::S_MERGE_NX: st_d = ffba_pkg::S_PV_RD;
			ffba_pkg::S_PV_RD: begin
				if (!ce_q.prv[LW-1]) st_d = ffba_pkg::S_PV_CHK;
				else if (mrg_q && !ce_q.nxt[LW-1]) st_d = ffba_pkg::S_FIX_AFTER2;
				else st_d = ffba_pkg::S_DONE;
			end
			ffba_pkg::S_PV_CHK: st_d = ((re.free || mrg_q) && !ce_q.nxt[LW-1])
				? ffba_pkg::S_FIX_AFTER2 : ffba_pkg::S_DONE;
			ffba_pkg::S_FIX_AFTER2: st_d = ffba_pkg::S_DONE;
			ffba_pkg::S_DONE: st_d = ffba_pkg::S_IDLE;
			default: st_d = ffba_pkg::S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		we = 1'b0;
		waddr = cur_q[SW-1:0];
		wdata = ce_q;
		raddr = cur_q[SW-1:0];
		unique case (st_q)
			ffba_pkg::S_INIT: begin
				we = 1'b1;
				waddr = cnt_q[SW-1:0];
				wdata = '{start: 32'd0, size: 32'd0, free: 1'b0, nxt: ffba_pkg::NoLink,
					prv: ffba_pkg::NoLink};
				if (cnt_q == '0) begin
					wdata.start = base_q;
					wdata.size = (size_q >= ffba_pkg::Hdr32) ? size_q - ffba_pkg::Hdr32 : 32'd0;
					wdata.free = 1'b1;
				end
			end
			ffba_pkg::S_ALLOC_WR: begin
				we = 1'b1;
				wdata.free = 1'b0;
				if (split) begin
					wdata.size = req_q;
					wdata.nxt = {1'b0, spare_idx};
				end
			end
			ffba_pkg::S_NEW_WR: begin
				we = 1'b1;
				waddr = nx_q[SW-1:0];
				raddr = after_q[SW-1:0];
				wdata = '{start: ce_q.start + req_q + ffba_pkg::Hdr32,
					size: ce_q.size - req_q - ffba_pkg::Hdr32, free: 1'b1,
					nxt: after_q, prv: cur_q};
			end
			ffba_pkg::S_FIX_AFTER: begin
				we = 1'b1;
				waddr = after_q[SW-1:0];
				wdata = re;
				wdata.prv = nx_q;
			end
			ffba_pkg::S_NX_RD: raddr = ce_q.nxt[SW-1:0];
			ffba_pkg::S_NX_CHK: raddr = ce_q.nxt[SW-1:0];
			ffba_pkg::S_MERGE_NX: begin
				we = 1'b1;
				wdata.size = ce_q.size + re.size + ffba_pkg::Hdr32;
				wdata.nxt = re.nxt;
				wdata.free = 1'b1;
			end
			ffba_pkg::S_PV_RD: begin
				raddr = ce_q.prv[LW-1] ? ce_q.nxt[SW-1:0] : ce_q.prv[SW-1:0];
				we = 1'b1;
				wdata.free = 1'b1;
			end
			ffba_pkg::S_PV_CHK: begin
				raddr = ce_q.nxt[SW-1:0];
				if (re.free) begin
					we = 1'b1;
					waddr = ce_q.prv[SW-1:0];
					wdata = re;
					wdata.size = re.size + ce_q.size + ffba_pkg::Hdr32;
					wdata.nxt = ce_q.nxt;
				end
			end
			ffba_pkg::S_FIX_AFTER2: begin
				we = 1'b1;
				waddr = ce_q.nxt[SW-1:0];
				wdata = re;
				wdata.prv = cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ffba_pkg::S_INIT;
			cnt_q <= '0;
			base_q <= 32'd0;
			size_q <= 32'd1048576;
			spare_q <= '0;
			ov_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (m_axis_tvalid && m_axis_tready) ov_q <= 1'b0;
			if (cfg_we && cfg_index == ffba_pkg::CfgBase) base_q <= cfg_data;
			if (size_wr) size_q <= cfg_data;
			unique case (st_q)
				ffba_pkg::S_INIT: begin
					cnt_q <= size_wr ? '0 : cnt_q + 1'b1;
					spare_q <= {{(ffba_pkg::MaxBlocks-1){1'b1}}, 1'b0};
				end
				ffba_pkg::S_IDLE: begin
					cnt_q <= '0;
					if (s_axis_tvalid && s_axis_tready) begin
						kind_q <= s_axis_tdata[0];
						req_q <= s_axis_tdata[32:1];
						want_q <= s_axis_tdata[64:33] - ffba_pkg::Hdr32;
						cur_q <= '0;
						mrg_q <= 1'b0;
						ost_q <= s_axis_tdata[0] ? ffba_pkg::StNullAddr : ffba_pkg::StZeroSize;
						ou_q <= 32'd0;
						og_q <= 32'd0;
					end
				end
				ffba_pkg::S_WALK_CHK: begin
					ce_q <= re;
					cnt_q <= cnt_q + 1'b1;
					after_q <= re.nxt;
					if (hit) ost_q <= ffba_pkg::StOk;
					else begin
						cur_q <= re.nxt;
						ost_q <= kind_q ? ffba_pkg::StNotFound : ffba_pkg::StNoMemory;
					end
				end
				ffba_pkg::S_ALLOC_WR: begin
					ou_q <= ce_q.start + ffba_pkg::Hdr32;
					og_q <= split ? req_q : ce_q.size;
					if (split) begin
						spare_q[spare_idx] <= 1'b0;
						// slot of the split-off block
						nx_q <= {1'b0, spare_idx};
					end
				end
				ffba_pkg::S_NX_CHK: if (re.free) nx_q <= ce_q.nxt;
				ffba_pkg::S_MERGE_NX: begin
					ce_q.size <= ce_q.size + re.size + ffba_pkg::Hdr32;
					ce_q.nxt <= re.nxt;
					spare_q[nx_q[SW-1:0]] <= 1'b1;
					mrg_q <= 1'b1;
				end
				ffba_pkg::S_PV_CHK: begin
					if (re.free) begin
						spare_q[cur_q[SW-1:0]] <= 1'b1;
						cur_q <= ce_q.prv;
						mrg_q <= 1'b1;
					end
				end
				ffba_pkg::S_DONE: ov_q <= 1'b1;
				default: ;
			endcase
		end
	end
endmodule

[tb/first_fit_block_allocator_core_test.sv]
// Testbench for first_fit_block_allocator_core: self-checking allocate/free traffic.
`timescale 1ns / 100ps

module first_fit_block_allocator_core_test;
	localparam logic KindAlloc = 1'b0;
	localparam logic KindFree  = 1'b1;
	localparam int   StallLimit = 5000;

	typedef struct {
		logic [2:0]  status;
		logic [31:0] user_address;
		logic [31:0] granted_size;
	} grant_t;

	class alloc_scoreboard;
		logic [31:0] blk_start [ffba_pkg::MaxBlocks];
		logic [31:0] blk_size  [ffba_pkg::MaxBlocks];
		bit          blk_free  [ffba_pkg::MaxBlocks];
		int          nxt       [ffba_pkg::MaxBlocks];
		int          prv       [ffba_pkg::MaxBlocks];
		bit          spare     [ffba_pkg::MaxBlocks];
		logic [31:0] base_reg;
		logic [31:0] size_reg;
		grant_t      grants_due [$];
		int          errors;

		function void clear_table();
			for (int i = 0; i < ffba_pkg::MaxBlocks; i++) begin
				blk_start[i] = 0;
				blk_size[i]  = 0;
				blk_free[i]  = 0;
				nxt[i]       = ffba_pkg::MaxBlocks;
				prv[i]       = ffba_pkg::MaxBlocks;
				spare[i]     = 1;
			end
			blk_start[0] = base_reg;
			blk_size[0]  = (size_reg >= ffba_pkg::Hdr32) ? size_reg - ffba_pkg::Hdr32 : 32'd0;
			blk_free[0]  = 1;
			spare[0]     = 0;
		endfunction

		function void power_up();
			base_reg = 0;
			size_reg = 32'd1048576;
			errors   = 0;
			clear_table();
		endfunction

		function void write_reg(logic idx, logic [31:0] v);
			if (idx == ffba_pkg::CfgBase) begin
				base_reg = v;
			end else begin
				size_reg = v;
				clear_table();
			end
		endfunction

		function void absorb(int lo, int hi);
			int after;
			after = nxt[hi];
			blk_size[lo] = blk_size[lo] + blk_size[hi] + ffba_pkg::Hdr32;
			nxt[lo] = after;
			if (after < ffba_pkg::MaxBlocks) prv[after] = lo;
			blk_start[hi] = 0;
			blk_size[hi]  = 0;
			blk_free[hi]  = 0;
			nxt[hi]       = ffba_pkg::MaxBlocks;
			prv[hi]       = ffba_pkg::MaxBlocks;
			spare[hi]     = 1;
		endfunction

		function grant_t note(logic kind, logic [31:0] req, logic [31:0] addr);
			grant_t r;
			int cur, steps, ns, after, nx, pv;
			logic [31:0] want;
			longint unsigned need;
			r.status = ffba_pkg::StOk;
			r.user_address = 0;
			r.granted_size = 0;
			cur = 0;
			if (kind == KindAlloc) begin
				if (req == 0) begin
					r.status = ffba_pkg::StZeroSize;
				end else begin
					for (steps = 0; steps < ffba_pkg::MaxBlocks && cur < ffba_pkg::MaxBlocks;
						steps++) begin
						if (blk_free[cur] && blk_size[cur] >= req) break;
						cur = nxt[cur];
					end
					if (steps >= ffba_pkg::MaxBlocks || cur >= ffba_pkg::MaxBlocks) begin
						r.status = ffba_pkg::StNoMemory;
					end else begin
						need = longint'(req) + 2 * ffba_pkg::HeaderBytes;
						ns = ffba_pkg::MaxBlocks;
						for (int i = ffba_pkg::MaxBlocks - 1; i >= 0; i--)
							if (spare[i]) ns = i;
						if (longint'(blk_size[cur]) > need && ns < ffba_pkg::MaxBlocks) begin
							after = nxt[cur];
							blk_start[ns] = blk_start[cur] + req + ffba_pkg::Hdr32;
							blk_size[ns]  = blk_size[cur] - req - ffba_pkg::Hdr32;
							blk_free[ns]  = 1;
							prv[ns] = cur;
							nxt[ns] = after;
							if (after < ffba_pkg::MaxBlocks) prv[after] = ns;
							spare[ns] = 0;
							nxt[cur] = ns;
							blk_size[cur] = req;
						end
						blk_free[cur] = 0;
						r.user_address = blk_start[cur] + ffba_pkg::Hdr32;
						r.granted_size = blk_size[cur];
					end
				end
			end else begin
				if (addr == 0) begin
					r.status = ffba_pkg::StNullAddr;
				end else begin
					want = addr - ffba_pkg::Hdr32;
					for (steps = 0; steps < ffba_pkg::MaxBlocks && cur < ffba_pkg::MaxBlocks;
						steps++) begin
						if (blk_start[cur] == want) break;
						cur = nxt[cur];
					end
					if (steps >= ffba_pkg::MaxBlocks || cur >= ffba_pkg::MaxBlocks) begin
						r.status = ffba_pkg::StNotFound;
					end else begin
						nx = nxt[cur];
						if (nx < ffba_pkg::MaxBlocks && blk_free[nx]) absorb(cur, nx);
						pv = prv[cur];
						if (pv < ffba_pkg::MaxBlocks && blk_free[pv]) begin
							absorb(pv, cur);
							cur = pv;
						end
						blk_free[cur] = 1;
					end
				end
			end
			grants_due.push_back(r);
			return r;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check(grant_t got);
			grant_t e;
			if (grants_due.size() == 0) begin
				report($sformatf("unexpected result status %0d", got.status));
			end else begin
				e = grants_due.pop_front();
				if (got.status !== e.status)
					report($sformatf("status %0d, want %0d", got.status, e.status));
				if (got.user_address !== e.user_address)
					report($sformatf("user_address %h, want %h", got.user_address,
						e.user_address));
				if (got.granted_size !== e.granted_size)
					report($sformatf("granted_size %h, want %h", got.granted_size,
						e.granted_size));
			end
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [71:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [31:0] cfg_data;

	alloc_scoreboard sb;
	logic [31:0] live_q [$];
	logic [31:0] freed_q [$];
	logic [31:0] store_bytes;
	bit          quiet;
	int          stall_left;
	int          idle_cycles;
	bit          s_fire;

	first_fit_block_allocator_core dut (.*);

	initial clk = 0;
	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		sb = new();
		sb.power_up();
		arst_n        = 0;
		s_axis_tvalid = 0;
		s_axis_tdata  = 0;
		m_axis_tready = 0;
		cfg_we        = 0;
		cfg_index     = 0;
		cfg_data      = 0;
		quiet         = 0;
		s_fire        = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
	end

	// result side: check, random stall bursts, watchdog
	always @(posedge clk or negedge arst_n) begin
		grant_t got;
		if (!arst_n) begin
			stall_left  <= 0;
			idle_cycles <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status       = m_axis_tdata[2:0];
				got.user_address = m_axis_tdata[34:3];
				got.granted_size = m_axis_tdata[66:35];
				sb.check(got);
			end
			if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= StallLimit) begin
				$display("first_fit_block_allocator_core_test: done, errors");
				$finish;
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				stall_left    <= $urandom_range(1, 19) - 1;
				m_axis_tready <= 0;
			end else begin
				m_axis_tready <= 1;
			end
		end
	end

	task send_item(logic kind, logic [31:0] req, logic [31:0] addr);
		grant_t e;
		s_axis_tvalid <= 1;
		s_axis_tdata  <= {7'd0, addr, req, kind};
		do @(posedge clk); while (!s_axis_tready);
		e = sb.note(kind, req, addr);
		if (kind == KindAlloc && e.status == ffba_pkg::StOk) live_q.push_back(e.user_address);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	task drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.grants_due.size() != 0) @(posedge clk);
		repeat (2 * ffba_pkg::MaxBlocks + 10) @(posedge clk);
	endtask

	task set_store(logic [31:0] base, logic [31:0] bytes);
		drain();
		cfg_we    <= 1;
		cfg_index <= ffba_pkg::CfgBase;
		cfg_data  <= base;
		@(posedge clk);
		cfg_index <= ffba_pkg::CfgSize;
		cfg_data  <= bytes;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(ffba_pkg::CfgBase, base);
		sb.write_reg(ffba_pkg::CfgSize, bytes);
		store_bytes = bytes;
		live_q.delete();
		freed_q.delete();
	endtask

	task free_live(int idx);
		logic [31:0] a;
		a = live_q[idx];
		live_q.delete(idx);
		freed_q.push_back(a);
		if (freed_q.size() > 16) void'(freed_q.pop_front());
		send_item(KindFree, $urandom, a);
	endtask

	task random_item();
		int pick;
		logic [31:0] cap;
		pick = $urandom_range(0, 99);
		cap = store_bytes >> 5;
		if (cap == 0) cap = 1;
		if (cap > 4096) cap = 4096;
		if (pick < 45 + (live_q.size() > 30 ? -20 : 0)) begin
			send_item(KindAlloc, $urandom_range(1, cap), $urandom);
		end else if (pick < 52) begin
			send_item(KindAlloc, $urandom_range(1, store_bytes), $urandom);
		end else if (pick < 55) begin
			send_item(KindAlloc, 0, $urandom);
		end else if (pick < 58) begin
			send_item(KindAlloc, $urandom, $urandom);
		end else if (pick < 86 && live_q.size() > 0) begin
			free_live($urandom_range(0, live_q.size() - 1));
		end else if (pick < 92 && freed_q.size() > 0) begin
			send_item(KindFree, $urandom, freed_q[$urandom_range(0, freed_q.size() - 1)]);
		end else if (pick < 95) begin
			send_item(KindFree, $urandom, 0);
		end else begin
			send_item(KindFree, $urandom, $urandom);
		end
	endtask

	initial begin
		logic [31:0] a;
		store_bytes = 32'd1048576;
		@(posedge arst_n);
		@(posedge clk);

		// directed part on the reset store
		send_item(KindAlloc, 0, 32'hFFFF_FFFF);
		send_item(KindAlloc, 32'hFFFF_FFFF, 32'h5555_5555);
		send_item(KindFree, 32'hFFFF_FFFF, 0);
		send_item(KindFree, 0, 32'hFFFF_FFFF);
		send_item(KindAlloc, 1, 32'hAAAA_AAAA);
		send_item(KindAlloc, 64, 0);
		send_item(KindAlloc, 100, 0);
		a = live_q[1];
		free_live(1);
		send_item(KindFree, 32'h1234_5678, a);
		free_live(0);
		free_live(0);
		send_item(KindAlloc, 32'd1048560, 0);
		send_item(KindAlloc, 1, 0);
		free_live(0);
		send_item(KindAlloc, 32'd1048560 - 32, 0);
		free_live(0);
		drain();

		// several store settings, random traffic in each
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_store(32'h0000_1000, 32'd4096);
				1: set_store(32'hFFFF_FF00, 32'h0000_0400);
				2: set_store(32'h0000_0000, 32'd32);
				3: set_store(32'hFFFF_FFFF, 32'hFFFF_FFFF);
				4: set_store($urandom, $urandom_range(256, 65536));
				default: set_store(32'h0000_0000, 32'd1048576);
			endcase
			for (int n = 0; n < 230; n++) begin
				if (ph == 5 && n == 150) quiet = 1;
				random_item();
			end
		end

		drain();
		if (sb.errors == 0)
			$display("first_fit_block_allocator_core_test: done, clean");
		else
			$display("first_fit_block_allocator_core_test: done, errors");
		$finish;
	end
endmodule
